// ===== src/slc_pkg.sv =====
// Shared constants, codes and controller/datapath types for the streaming convolution block.
package slc_pkg;

    localparam int MAX_TAPS    = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_W     = $clog2(MAX_TAPS);
    localparam int CNT_W      = $clog2(MAX_TAPS + 1);
    localparam int PROD_W     = 2 * SAMPLE_BITS;
    localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int OUT_W      = 32;
    localparam int EXT_W      = (ACC_W > OUT_W + 1) ? ACC_W : OUT_W + 1;
    localparam int TAP_W      = 11;
    localparam int COEF_IDX_W = 10;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [TAP_W-1:0] TAP_COUNT_RESET = TAP_W'(1);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SAMPLE_BITS - 2);
    localparam logic signed [EXT_W-1:0] SAT_HI     = EXT_W'(2147483647);
    localparam logic signed [EXT_W-1:0] SAT_LO     = -SAT_HI - EXT_W'(1);

    localparam logic ACT_COEF   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic REG_TAP_COUNT = 1'b0;

    typedef struct packed {
        logic coef_wr;
        logic start;
        logic step;
        logic load_out;
    } t_slc_cmd;

    typedef struct packed {
        logic walk_done;
        logic pipe_busy;
        logic out_free;
    } t_slc_sts;

endpackage

// ===== src/slc_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface slc_in_if import slc_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [COEF_IDX_W-1:0]         coef_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          first;

    modport source (output valid, action, coef_index, value, first, input ready);
    modport sink   (input valid, action, coef_index, value, first, output ready);
endinterface

interface slc_out_if import slc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_value;
    logic                    saturated;

    modport source (output valid, out_value, saturated, input ready);
    modport sink   (input valid, out_value, saturated, output ready);
endinterface

// ===== src/slc_ctrl.sv =====
// Controller state machine that sequences the multiply-accumulate walk for each sample.
module slc_ctrl import slc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_action,
    output logic     o_ready,
    input  t_slc_sts i_sts,
    output t_slc_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    always_comb begin
        o_cmd.coef_wr  = i_valid && r_ready && (i_action == ACT_COEF);
        o_cmd.start    = i_valid && r_ready && (i_action == ACT_SAMPLE);
        o_cmd.step     = (r_state == S_MAC) && !i_sts.walk_done;
        o_cmd.load_out = (r_state == S_EMIT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (i_sts.walk_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_ready = r_ready;

`ifndef SYNTH
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.pipe_busy)
        else $error("accumulator pipeline busy while idle");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready == (r_state == S_IDLE))
        else $error("ready out of step with controller state");
    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_sts.pipe_busy)
        else $error("result loaded while products still in flight");
`endif

endmodule

// ===== src/slc_dp.sv =====
// Datapath with coefficient and history memories, shared multiply-accumulate and output register.
module slc_dp import slc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_slc_cmd                      i_cmd,
    output t_slc_sts                      o_sts,
    input  logic [TAP_W-1:0]              i_tap_count,
    input  logic [COEF_IDX_W-1:0]         i_coef_index,
    input  logic signed [SAMPLE_BITS-1:0] i_value,
    input  logic                          i_first,
    slc_out_if.source                     o_out
);

    logic signed [SAMPLE_BITS-1:0] r_coef_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_hist_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_coef_q;
    logic signed [SAMPLE_BITS-1:0] r_hist_q;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic [ADDR_W-1:0]             r_ptr;
    logic [ADDR_W-1:0]             r_rd_idx;
    logic [CNT_W-1:0]              r_vc;
    logic [CNT_W-1:0]              r_k;
    logic [CNT_W-1:0]              r_walk;
    logic                          r_v1;
    logic                          r_v2;
    logic                          r_out_valid;
    logic signed [OUT_W-1:0]       r_out_value;
    logic                          r_out_sat;

    logic [CNT_W-1:0]        n_vc;
    logic [CNT_W-1:0]        taps_clip;
    logic [CNT_W-1:0]        n_walk;
    logic                    coef_in_range;
    logic signed [ACC_W-1:0] rounded;
    logic signed [EXT_W-1:0] y_ext;
    logic                    sat_hi;
    logic                    sat_lo;

    always_comb begin
        coef_in_range = 32'(i_coef_index) < 32'(MAX_TAPS);
        taps_clip     = (32'(i_tap_count) > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                           : CNT_W'(i_tap_count);
        if (i_first) begin
            n_vc = CNT_W'(1);
        end else if (r_vc < CNT_W'(MAX_TAPS)) begin
            n_vc = r_vc + 1'b1;
        end else begin
            n_vc = r_vc;
        end
        n_walk  = (taps_clip < n_vc) ? taps_clip : n_vc;
        rounded = (r_acc + ROUND_HALF) >>> (SAMPLE_BITS - 1);
        y_ext   = EXT_W'(rounded);
        sat_hi  = y_ext > SAT_HI;
        sat_lo  = y_ext < SAT_LO;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr && coef_in_range) begin
            r_coef_mem[ADDR_W'(i_coef_index)] <= i_value;
        end
        if (i_cmd.start) begin
            r_hist_mem[r_ptr] <= i_value;
        end
        if (i_cmd.step) begin
            r_coef_q <= r_coef_mem[r_k[ADDR_W-1:0]];
            r_hist_q <= r_hist_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_vc   <= '0;
            r_k    <= '0;
            r_walk <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            r_v1 <= i_cmd.step;
            r_v2 <= r_v1;
            if (i_cmd.start) begin
                r_ptr  <= (r_ptr == ADDR_W'(MAX_TAPS - 1)) ? '0 : r_ptr + 1'b1;
                r_vc   <= n_vc;
                r_k    <= '0;
                r_walk <= n_walk;
            end else if (i_cmd.step) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rd_idx <= r_ptr;
            r_acc    <= '0;
        end else begin
            if (i_cmd.step) begin
                r_rd_idx <= (r_rd_idx == '0) ? ADDR_W'(MAX_TAPS - 1) : r_rd_idx - 1'b1;
            end
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (r_v1) begin
            r_prod <= r_coef_q * r_hist_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_sat <= sat_hi || sat_lo;
            if (sat_hi) begin
                r_out_value <= SAT_HI[OUT_W-1:0];
            end else if (sat_lo) begin
                r_out_value <= SAT_LO[OUT_W-1:0];
            end else begin
                r_out_value <= y_ext[OUT_W-1:0];
            end
        end
    end

    always_comb begin
        o_sts.walk_done = (r_k == r_walk);
        o_sts.pipe_busy = r_v1 || r_v2;
        o_sts.out_free  = !r_out_valid || o_out.ready;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_out_value;
    assign o_out.saturated = r_out_sat;

`ifndef SYNTH
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= r_walk)
        else $error("tap counter ran past the walk length");
    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("accumulate without a preceding product");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_vc) <= 32'(MAX_TAPS)) && (32'(r_walk) <= 32'(r_vc)))
        else $error("history count or walk length out of range");
`endif

endmodule

// ===== src/streaming_linear_convolution.sv =====
// Streaming linear convolution top level with APB tap-count register.
//
// Input items arrive on i_in (valid/ready). An item with action 0 writes one
// coefficient of the impulse response and is taken without leaving idle, with no
// result. An item with action 1 pushes a sample; first starts a new block so
// that earlier history counts as zero. Each sample gives one result item on
// o_out holding y[n] rounded to Q1.15 scale and saturated to 32 bits.
// One shared multiply-accumulate walks the taps, one coefficient and history
// pair per cycle, for the smaller of tap_count and the samples seen in the
// block. Each step reads a coefficient and a history value into registers;
// the product is registered and then summed into the accumulator, and after
// the walk the pipeline drains before the rounded result is loaded. i_in.ready
// drops while a sample is in work and returns the cycle after its result is
// loaded. The result sits in an output register; the next item is accepted
// while it waits, and a stalled receiver holds the following sample at its
// final step. tap_count is written over APB at address 0; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Synchronous reset clears control state and sets tap_count to 1; the
// coefficient and history memories are not cleared.
module streaming_linear_convolution import slc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    slc_in_if.sink             i_in,
    slc_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [TAP_W-1:0] r_tap_count;
    t_slc_cmd         cmd;
    t_slc_sts         sts;
    logic             ctrl_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_TAP_COUNT)) begin
            r_tap_count <= pwdata[TAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TAP_COUNT) ? PDATA_W'(r_tap_count) : '0;

    slc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_action (i_in.action),
        .o_ready  (ctrl_ready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    assign i_in.ready = ctrl_ready;

    slc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_tap_count  (r_tap_count),
        .i_coef_index (i_in.coef_index),
        .i_value      (i_in.value),
        .i_first      (i_in.first),
        .o_out        (o_out)
    );

endmodule
